FILE: rtl/core/rss_pkg.sv
package rss_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MUL_SQ,
        ST_MUL_SUM,
        ST_DIV_MEAN,
        ST_DIV_VAR,
        ST_SQRT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic load_mul_sq;
        logic load_mul_sum;
        logic save_nsq;
        logic load_div_mean;
        logic save_mean;
        logic load_div_var;
        logic load_sqrt;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } status_t;

    localparam int unsigned VOLUME_BITS = 48;
    localparam int unsigned VOXEL_BITS  = 32;
    localparam logic [VOXEL_BITS-1:0] VOXEL_RESET = 32'd65536;

endpackage

FILE: rtl/core/rss_ctrl.sv
module rss_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_end_of_set,
    output logic              s_ready,
    input  rss_pkg::status_t  status,
    output rss_pkg::cmd_t     cmd
);

    rss_pkg::state_t state_reg;
    rss_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rss_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rss_pkg::ST_IDLE: begin
                if (s_valid && s_end_of_set) state_next = rss_pkg::ST_START;
            end
            rss_pkg::ST_START: begin
                state_next = rss_pkg::ST_MUL_SQ;
            end
            rss_pkg::ST_MUL_SQ: begin
                if (status.mul_done) state_next = rss_pkg::ST_MUL_SUM;
            end
            rss_pkg::ST_MUL_SUM: begin
                if (status.mul_done) state_next = rss_pkg::ST_DIV_MEAN;
            end
            rss_pkg::ST_DIV_MEAN: begin
                if (status.div_done) state_next = rss_pkg::ST_DIV_VAR;
            end
            rss_pkg::ST_DIV_VAR: begin
                if (status.div_done) state_next = rss_pkg::ST_SQRT;
            end
            rss_pkg::ST_SQRT: begin
                if (status.sqrt_done) state_next = rss_pkg::ST_OUT;
            end
            rss_pkg::ST_OUT: begin
                if (status.out_free) state_next = rss_pkg::ST_IDLE;
            end
            default: state_next = rss_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            rss_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            // closing sample is in the accumulators by now
            rss_pkg::ST_START: begin
                cmd.load_mul_sq = 1'b1;
            end
            rss_pkg::ST_MUL_SQ: begin
                cmd.save_nsq     = status.mul_done;
                cmd.load_mul_sum = status.mul_done;
            end
            rss_pkg::ST_MUL_SUM: begin
                cmd.load_div_mean = status.mul_done;
            end
            rss_pkg::ST_DIV_MEAN: begin
                cmd.save_mean    = status.div_done;
                cmd.load_div_var = status.div_done;
            end
            rss_pkg::ST_DIV_VAR: begin
                cmd.load_sqrt = status.div_done;
            end
            rss_pkg::ST_SQRT: begin
            end
            rss_pkg::ST_OUT: begin
                cmd.load_out = status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/core/rss_datapath.sv
module rss_datapath #(
    parameter int unsigned SAMPLE_BITS = 20,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rss_pkg::cmd_t                       cmd,
    output rss_pkg::status_t                    status,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample,
    input  logic                                s_has_sample,
    input  logic                                cfg_valid,
    input  logic [rss_pkg::VOXEL_BITS-1:0]      cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [COUNT_BITS-1:0]               m_point_count,
    output logic [rss_pkg::VOLUME_BITS-1:0]     m_region_volume,
    output logic signed [SAMPLE_BITS-1:0]       m_mean_value,
    output logic [SAMPLE_BITS-2:0]              m_std_dev,
    output logic signed [SAMPLE_BITS-1:0]       m_min_value,
    output logic signed [SAMPLE_BITS-1:0]       m_max_value,
    output logic                                m_empty_error,
    output logic                                m_count_overflow
);

    localparam int unsigned SB     = SAMPLE_BITS;
    localparam int unsigned CB     = COUNT_BITS;
    localparam int unsigned SUM_W  = SB + CB;
    localparam int unsigned SQ_RAW = 2 * SB - 2 + CB;
    localparam int unsigned SQ_W   = (SQ_RAW > 64) ? 64 : SQ_RAW;
    localparam int unsigned NSQ_W  = CB + SQ_W;
    localparam int unsigned PROD_W = (NSQ_W > 2 * SUM_W) ? NSQ_W : 2 * SUM_W;
    localparam int unsigned QW     = 2 * SB - 1;
    localparam int unsigned DW     = 2 * CB;
    localparam int unsigned HI_W   = PROD_W - QW;
    localparam int unsigned CMP_W  = (HI_W > DW) ? HI_W : DW;
    localparam int unsigned RW     = 2 * SB;
    localparam int unsigned VP_RAW = CB + rss_pkg::VOXEL_BITS;
    localparam int unsigned VP_W   = (VP_RAW > rss_pkg::VOLUME_BITS) ?
                                     VP_RAW : rss_pkg::VOLUME_BITS + 1;
    localparam int unsigned MC_W   = $clog2(SUM_W + 1);
    localparam int unsigned DC_W   = $clog2(QW + 1);
    localparam int unsigned RC_W   = $clog2(SB + 1);

    localparam logic [CB-1:0]   COUNT_MAX = {CB{1'b1}};
    localparam logic [SB-2:0]   STD_MAX   = {(SB-1){1'b1}};
    localparam logic [VP_W-1:0] VOL_MAX   = VP_W'({rss_pkg::VOLUME_BITS{1'b1}});

    // configuration
    logic [rss_pkg::VOXEL_BITS-1:0] voxel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            voxel_reg <= rss_pkg::VOXEL_RESET;
        end else if (cfg_valid) begin
            voxel_reg <= cfg_data;
        end
    end

    // accumulators
    logic [CB-1:0]           count_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic signed [SB-1:0]    min_reg;
    logic signed [SB-1:0]    max_reg;
    logic                    ovf_reg;

    logic [SB-1:0]   mag;
    logic [2*SB-1:0] sq;
    logic [SQ_W:0]   sq_sum;

    assign mag    = s_sample[SB-1] ? (~s_sample + 1'b1) : s_sample;
    assign sq     = mag * mag;
    assign sq_sum = (SQ_W + 1)'(sq_reg) + (SQ_W + 1)'(sq);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.load_out) begin
            count_reg <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.accept && s_has_sample) begin
            if (count_reg == COUNT_MAX) begin
                ovf_reg <= 1'b1;
            end else begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + SUM_W'(s_sample);
                sq_reg    <= sq_sum[SQ_W] ? {SQ_W{1'b1}} : sq_sum[SQ_W-1:0];
                if (count_reg == '0 || s_sample < min_reg) min_reg <= s_sample;
                if (count_reg == '0 || s_sample > max_reg) max_reg <= s_sample;
            end
        end
    end

    logic [SUM_W-1:0] abs_sum;
    assign abs_sum = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;

    // serial shift-add multiplier
    logic [PROD_W-1:0] mcand_reg;
    logic [SUM_W-1:0]  mplier_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [MC_W-1:0]   mcnt_reg;
    logic [PROD_W-1:0] nsq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mcnt_reg <= '0;
        end else if (cmd.load_mul_sq || cmd.load_mul_sum) begin
            mcnt_reg <= MC_W'(SUM_W);
        end else if (mcnt_reg != '0) begin
            mcnt_reg <= mcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.save_nsq) nsq_reg <= acc_reg;
        if (cmd.load_mul_sq) begin
            mcand_reg  <= PROD_W'(sq_reg);
            mplier_reg <= SUM_W'(count_reg);
            acc_reg    <= '0;
        end else if (cmd.load_mul_sum) begin
            mcand_reg  <= PROD_W'(abs_sum);
            mplier_reg <= abs_sum;
            acc_reg    <= '0;
        end else if (mcnt_reg != '0) begin
            if (mplier_reg[0]) acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    // restoring divider, saturating quotient
    logic [PROD_W-1:0] div_x;
    logic [DW-1:0]     div_d;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     dsr_reg;
    logic [QW-1:0]     num_reg;
    logic [QW-1:0]     quo_reg;
    logic [DC_W-1:0]   dcnt_reg;
    logic [HI_W-1:0]   div_hi;
    logic              div_sat;
    logic [DW:0]       trial;
    logic              trial_ok;

    always_comb begin
        if (cmd.load_div_var) begin
            div_x = (nsq_reg >= acc_reg) ? (nsq_reg - acc_reg) : '0;
            div_d = DW'(count_reg) * DW'(count_reg - 1'b1);
        end else begin
            div_x = PROD_W'({abs_sum, 1'b0}) + PROD_W'(count_reg);
            div_d = DW'({count_reg, 1'b0});
        end
    end

    assign div_hi   = div_x[PROD_W-1:QW];
    assign div_sat  = CMP_W'(div_hi) >= CMP_W'(div_d);
    assign trial    = {rem_reg, num_reg[QW-1]};
    assign trial_ok = trial >= (DW + 1)'(dsr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (cmd.load_div_mean || cmd.load_div_var) begin
            dcnt_reg <= div_sat ? '0 : DC_W'(QW);
        end else if (dcnt_reg != '0) begin
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_div_mean || cmd.load_div_var) begin
            dsr_reg <= div_d;
            rem_reg <= DW'(div_hi);
            num_reg <= div_x[QW-1:0];
            quo_reg <= div_sat ? {QW{1'b1}} : '0;
        end else if (dcnt_reg != '0) begin
            rem_reg <= trial_ok ? DW'(trial - (DW + 1)'(dsr_reg)) : DW'(trial);
            num_reg <= num_reg << 1;
            quo_reg <= {quo_reg[QW-2:0], trial_ok};
        end
    end

    logic signed [SB-1:0] mean_reg;

    always_ff @(posedge aclk) begin
        if (cmd.save_mean) begin
            mean_reg <= sum_reg[SUM_W-1] ? -quo_reg[SB-1:0] : quo_reg[SB-1:0];
        end
    end

    // digit-by-digit square root, one result bit per step
    logic [RW-1:0]   rx_reg;
    logic [RW-1:0]   rr_reg;
    logic [RW-1:0]   rb_reg;
    logic [RC_W-1:0] rcnt_reg;
    logic [RW-1:0]   r_plus_b;

    assign r_plus_b = rr_reg + rb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rcnt_reg <= '0;
        end else if (cmd.load_sqrt) begin
            rcnt_reg <= RC_W'(SB);
        end else if (rcnt_reg != '0) begin
            rcnt_reg <= rcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_sqrt) begin
            rx_reg <= RW'(quo_reg);
            rr_reg <= '0;
            rb_reg <= RW'(1) << (RW - 2);
        end else if (rcnt_reg != '0) begin
            if (rx_reg >= r_plus_b) begin
                rx_reg <= rx_reg - r_plus_b;
                rr_reg <= (rr_reg >> 1) + rb_reg;
            end else begin
                rr_reg <= rr_reg >> 1;
            end
            rb_reg <= rb_reg >> 2;
        end
    end

    logic [SB-2:0] std_clamped;
    assign std_clamped = (rr_reg[SB-1:0] > SB'(STD_MAX)) ? STD_MAX : rr_reg[SB-2:0];

    // volume
    logic [VP_RAW-1:0] vol_prod;
    logic [VP_W-1:0]   vol_ext;
    assign vol_prod = VP_RAW'(count_reg) * VP_RAW'(voxel_reg);
    assign vol_ext  = VP_W'(vol_prod);

    // output register
    logic m_valid_reg;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_point_count    <= count_reg;
            m_region_volume  <= (vol_ext > VOL_MAX) ? {rss_pkg::VOLUME_BITS{1'b1}}
                                                    : vol_ext[rss_pkg::VOLUME_BITS-1:0];
            m_mean_value     <= (count_reg != '0) ? mean_reg : '0;
            m_std_dev        <= (count_reg > CB'(1)) ? std_clamped : '0;
            m_min_value      <= min_reg;
            m_max_value      <= max_reg;
            m_empty_error    <= (count_reg == '0);
            m_count_overflow <= ovf_reg;
        end
    end

    assign m_valid = m_valid_reg;

    assign status.mul_done  = (mcnt_reg == '0);
    assign status.div_done  = (dcnt_reg == '0);
    assign status.sqrt_done = (rcnt_reg == '0);
    assign status.out_free  = out_free;

endmodule

FILE: rtl/core/region_sample_statistics_top.sv
// Region sample statistics. Each input item may carry one signed fixed-point sample
// (has_sample) and may close the set (end_of_set); a closing item yields one result
// with the count, count times voxel volume, rounded mean, sample standard deviation,
// min and max, then clears the accumulators. An item without end_of_set does not
// drop s_ready. A closing item holds s_ready low through a start state, the
// bit-serial multiplier run twice, the restoring divider run twice, the
// one-bit-per-cycle square root and the output load; an empty set finishes sooner since
// its divisions end at once, and the output load waits while an earlier result is
// still held. A finished result waits in the output register while the next set
// accumulates. voxel_volume must be written through cfg_* only while idle; the
// block itself does not enforce this.
module region_sample_statistics_top #(
    parameter int unsigned SAMPLE_BITS = 20,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rss_pkg::VOXEL_BITS-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [SAMPLE_BITS-1:0]     s_sample,
    input  logic                              s_has_sample,
    input  logic                              s_end_of_set,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [COUNT_BITS-1:0]             m_point_count,
    output logic [rss_pkg::VOLUME_BITS-1:0]   m_region_volume,
    output logic signed [SAMPLE_BITS-1:0]     m_mean_value,
    output logic [SAMPLE_BITS-2:0]            m_std_dev,
    output logic signed [SAMPLE_BITS-1:0]     m_min_value,
    output logic signed [SAMPLE_BITS-1:0]     m_max_value,
    output logic                              m_empty_error,
    output logic                              m_count_overflow
);

    rss_pkg::cmd_t    cmd;
    rss_pkg::status_t status;

    assign cfg_ready = 1'b1;

    rss_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_end_of_set (s_end_of_set),
        .s_ready      (s_ready),
        .status       (status),
        .cmd          (cmd)
    );

    rss_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_sample         (s_sample),
        .s_has_sample     (s_has_sample),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_point_count    (m_point_count),
        .m_region_volume  (m_region_volume),
        .m_mean_value     (m_mean_value),
        .m_std_dev        (m_std_dev),
        .m_min_value      (m_min_value),
        .m_max_value      (m_max_value),
        .m_empty_error    (m_empty_error),
        .m_count_overflow (m_count_overflow)
    );

endmodule

FILE: tb/tb_region_sample_statistics_top.sv
module tb_region_sample_statistics_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB = 20;
    localparam int CB = 16;
    localparam logic [63:0] COUNT_FULL = (64'd1 << CB) - 1;

    typedef struct packed {
        logic [CB-1:0]                  point_count;
        logic [rss_pkg::VOLUME_BITS-1:0] region_volume;
        logic [SB-1:0]                  mean_value;
        logic [SB-2:0]                  std_dev;
        logic [SB-1:0]                  min_value;
        logic [SB-1:0]                  max_value;
        logic                           empty_error;
        logic                           count_overflow;
    } stats_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [rss_pkg::VOXEL_BITS-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [SB-1:0] s_sample = '0;
    logic s_has_sample = 1'b0;
    logic s_end_of_set = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [CB-1:0] m_point_count;
    logic [rss_pkg::VOLUME_BITS-1:0] m_region_volume;
    logic signed [SB-1:0] m_mean_value;
    logic [SB-2:0] m_std_dev;
    logic signed [SB-1:0] m_min_value;
    logic signed [SB-1:0] m_max_value;
    logic m_empty_error;
    logic m_count_overflow;

    region_sample_statistics_top #(.SAMPLE_BITS(SB), .COUNT_BITS(CB)) dut (.*);

    // predictor state
    logic [31:0]       voxel_vol;
    logic [63:0]       acc_count;
    logic signed [63:0] acc_sum;
    logic [127:0]      acc_sq;
    logic signed [63:0] acc_min, acc_max;
    logic              acc_ovf;

    stats_t expected_stats[$];
    int errors = 0;
    int results_seen = 0;
    int sets_closed = 0;
    bit idle_on = 1'b1;

    initial forever #6 aclk = ~aclk;

    initial begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [63:0] isqrt(input logic [127:0] x);
        logic [63:0] r;
        logic [127:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t[63:0];
        end
        return r;
    endfunction

    task automatic clear_acc();
        acc_count = 0;
        acc_sum = 0;
        acc_sq = 0;
        acc_min = 0;
        acc_max = 0;
        acc_ovf = 1'b0;
    endtask

    task automatic predict_stats(input logic [SB-1:0] smp, input logic hs, input logic eos);
        logic signed [63:0] v;
        logic [63:0] au, mean, sd, vol;
        logic [127:0] num, var_q, lhs, rhs;
        stats_t r;
        v = $signed(smp);
        if (hs) begin
            if (acc_count >= COUNT_FULL) acc_ovf = 1'b1;
            else begin
                if (acc_count == 0) begin
                    acc_min = v;
                    acc_max = v;
                end else begin
                    if (v < acc_min) acc_min = v;
                    if (v > acc_max) acc_max = v;
                end
                acc_count++;
                acc_sum += v;
                acc_sq += 128'(v * v);
            end
        end
        if (!eos) return;
        sets_closed++;
        vol = acc_count * voxel_vol;
        if (vol > 64'hFFFF_FFFF_FFFF) vol = 64'hFFFF_FFFF_FFFF;
        mean = 0;
        sd = 0;
        au = acc_sum < 0 ? -acc_sum : acc_sum;
        if (acc_count > 0) begin
            mean = (2 * au + acc_count) / (2 * acc_count);
            if (acc_sum < 0) mean = -mean;
        end
        if (acc_count > 1) begin
            lhs = 128'(acc_count) * acc_sq;
            rhs = 128'(au) * 128'(au);
            num = lhs < rhs ? 128'd0 : lhs - rhs;
            var_q = num / (128'(acc_count) * 128'(acc_count - 1));
            sd = isqrt(var_q);
            if (sd > (64'd1 << (SB - 1)) - 1) sd = (64'd1 << (SB - 1)) - 1;
        end
        r.point_count = acc_count[CB-1:0];
        r.region_volume = vol[47:0];
        r.mean_value = mean[SB-1:0];
        r.std_dev = sd[SB-2:0];
        r.min_value = acc_min[SB-1:0];
        r.max_value = acc_max[SB-1:0];
        r.empty_error = acc_count == 0;
        r.count_overflow = acc_ovf;
        expected_stats.push_back(r);
        clear_acc();
    endtask

    task automatic idle_gap();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
    endtask

    // valid stays up after an accept so the next item can follow at once
    task automatic send_item(input logic [SB-1:0] smp, input logic hs, input logic eos);
        idle_gap();
        s_valid <= 1'b1;
        s_sample <= smp;
        s_has_sample <= hs;
        s_end_of_set <= eos;
        do @(posedge aclk); while (!s_ready);
        predict_stats(smp, hs, eos);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_stats.size() != 0) @(negedge aclk);
        repeat (150) @(negedge aclk);
    endtask

    task automatic write_volume(input logic [31:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        voxel_vol = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // result checker and output stall
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            stats_t got, exp_r;
            got = '{m_point_count, m_region_volume, m_mean_value, m_std_dev,
                    m_min_value, m_max_value, m_empty_error, m_count_overflow};
            results_seen++;
            if (expected_stats.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
            end else begin
                exp_r = expected_stats.pop_front();
                if (got !== exp_r) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: exp %p got %p", exp_r, got);
                end
            end
        end
    end

    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 10);
                repeat (n - 1) @(negedge aclk);
            end else m_ready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_item('0, 1'b0, 1'b1);                     // empty set
        send_item(20'sh7FFFF, 1'b1, 1'b1);             // one sample with end
        send_item(20'sh80000, 1'b1, 1'b0);
        send_item(20'sh7FFFF, 1'b1, 1'b0);
        send_item(20'h12345, 1'b0, 1'b0);              // nothing
        send_item(20'sh80000, 1'b1, 1'b1);
        send_item(20'shFFFFF, 1'b1, 1'b0);
        send_item(20'sh00001, 1'b1, 1'b0);
        send_item(20'sh00002, 1'b1, 1'b1);
        send_item(-20'sd3, 1'b1, 1'b0);
        send_item(-20'sd4, 1'b1, 1'b0);
        send_item('0, 1'b0, 1'b1);
    endtask

    task automatic test_random_sets(input int n_items);
        int len;
        logic [SB-1:0] base, v;
        for (int it = 0; it < n_items; ) begin
            len = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom_range(2, 30);
            base = SB'($urandom);
            for (int k = 0; k < len; k++) begin
                v = $urandom_range(0, 1) ? SB'(base + $urandom_range(0, 200) - 100)
                                         : SB'($urandom);
                send_item(v, $urandom_range(0, 7) != 0, 1'b0);
                it++;
            end
            send_item(SB'($urandom), 1'($urandom_range(0, 1)), 1'b1);
            it++;
        end
    endtask

    // random sets with no idling on either side
    task automatic test_no_idle();
        idle_on = 1'b0;
        test_random_sets(390);
    endtask

    initial begin
        voxel_vol = rss_pkg::VOXEL_RESET;
        clear_acc();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        write_volume('0);
        test_directed();
        write_volume(32'hFFFF_FFFF);
        test_directed();
        write_volume(32'h0001_8000);
        test_random_sets(390);
        write_volume($urandom);
        test_no_idle();
        drain();
        $display("closed %0d sets, checked %0d results, voxel volume swept incl. 0 and max",
                 sets_closed, results_seen);
        if (errors == 0 && expected_stats.size() == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
